// File: hdl/tcbht_pkg.sv
`timescale 1ns / 1ps

package tcbht_pkg;

  localparam int KEY_W = 64;
  localparam int ROW_W = 16;
  localparam int REMOVED_W = 4;

  // Bits of the identifier folded into the bucket remainder per cycle.
  localparam int DIGIT_W = 8;
  localparam int DIGIT_STEPS = KEY_W / DIGIT_W;

  localparam int IN_DATA_W = 2 * KEY_W + ROW_W;
  localparam int OUT_DATA_W = 24;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_DUPLICATE = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;
  localparam logic [1:0] STATUS_REMOVE_COUNT = 2'd3;

endpackage

// File: hdl/two_choice_bucket_hash_table.sv
`timescale 1ns / 1ps

// Two-choice bucketed hash table mapping a 128-bit identifier to a 16-bit row.
// Requests arrive on the s_ channel: s_tuser carries the opcode (lookup, insert,
// remove) and s_tdata carries uuid_low, uuid_high and row. Each request gives
// exactly one result on the m_ channel with found, found_row, status and
// removed_count.
// A request is folded into both bucket indexes eight bits per cycle, then the
// 2*SLOTS_PER_BUCKET slots of both buckets are read one per cycle through the
// single key memory read port. Lookup and insert then load the result; remove
// first clears its matches one slot per cycle and then loads the result.
// s_tready is high again in the cycle after the result is loaded, so one
// request is in progress at a time.
// After rst the block sweeps the key memory to empty, one entry per cycle,
// with s_tready low.
// The result sits in an output register; while the receiver stalls the block
// still accepts and works on one more request, and holds it until the output
// register frees.
module two_choice_bucket_hash_table
  import tcbht_pkg::*;
#(
  parameter int BUCKET_COUNT = 64,
  parameter int SLOTS_PER_BUCKET = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // uuid_low [63:0], uuid_high [127:64], row [143:128]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // opcode [1:0]
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // found [0], found_row [16:1], status [18:17], removed_count [22:19], zero [23]
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int TABLE_DEPTH = BUCKET_COUNT * SLOTS_PER_BUCKET;
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int RW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int SCAN_N = 2 * SLOTS_PER_BUCKET;
  localparam int IW = $clog2(SCAN_N);
  localparam int PW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int CW = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int NW = $clog2(SCAN_N + 1);
  localparam int DW = $clog2(DIGIT_STEPS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_DRAIN,
    S_POST,
    S_REMOVE,
    S_DONE
  } state_t;

  state_t state;

  logic [1:0]       op;
  logic [KEY_W-1:0] key1;
  logic [KEY_W-1:0] key2;
  logic [ROW_W-1:0] row;
  logic [RW-1:0]    rem1;
  logic [RW-1:0]    rem2;
  logic [DW-1:0]    digit;
  logic [AW-1:0]    base1;
  logic [AW-1:0]    base2;
  logic [AW-1:0]    clr;
  logic [IW-1:0]    idx;
  logic [IW-1:0]    pidx;
  logic [AW-1:0]    paddr;
  logic             pvalid;
  logic             m1_cur;
  logic             hit;
  logic [AW-1:0]    win;
  logic             dup;
  logic [CW-1:0]    empty1;
  logic [CW-1:0]    empty2;
  logic [PW-1:0]    free1;
  logic [PW-1:0]    free2;
  logic [SCAN_N-1:0] mask;
  logic [NW-1:0]    rm_count;

  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [ROW_W-1:0] row_mem [TABLE_DEPTH];
  logic [KEY_W-1:0] key_rdata;
  logic [ROW_W-1:0] row_rdata;

  logic             key_we;
  logic             row_we;
  logic [AW-1:0]    key_waddr;
  logic [KEY_W-1:0] key_wdata;
  logic [AW-1:0]    scan_addr;

  logic [RW-1:0]    rem1_next;
  logic [RW-1:0]    rem2_next;

  logic [KEY_W-1:0] sel_key;
  logic             slot_hit;
  logic             slot_empty;
  logic [PW-1:0]    ppos;

  logic             ins1;
  logic             ins2;
  logic [AW-1:0]    ins_addr;
  logic [KEY_W-1:0] ins_key;

  logic             res_found;
  logic [ROW_W-1:0] res_row;
  logic [1:0]       res_status;
  logic [REMOVED_W-1:0] res_removed;

  function automatic logic [RW-1:0] mod_digit(input logic [RW-1:0] r,
                                              input logic [DIGIT_W-1:0] d);
    logic [RW:0] t;
    logic [RW-1:0] acc;
    acc = r;
    for (int b = DIGIT_W - 1; b >= 0; b--) begin
      t = {acc, d[b]};
      if (t >= (RW + 1)'(BUCKET_COUNT)) begin
        t = t - (RW + 1)'(BUCKET_COUNT);
      end
      acc = t[RW-1:0];
    end
    return acc;
  endfunction

  assign rem1_next = mod_digit(rem1, key1[KEY_W - 1 - DIGIT_W * int'(digit) -: DIGIT_W]);
  assign rem2_next = mod_digit(rem2, key2[KEY_W - 1 - DIGIT_W * int'(digit) -: DIGIT_W]);

  assign scan_addr = (idx[0] ? base2 : base1) + AW'(PW'(idx >> 1));

  assign sel_key = pidx[0] ? key2 : key1;
  assign slot_hit = (sel_key != '0) && (key_rdata == sel_key);
  assign slot_empty = (key_rdata == '0);
  assign ppos = PW'(pidx >> 1);

  assign ins1 = empty1 > empty2;
  assign ins2 = !ins1 && (empty2 != '0);
  assign ins_addr = ins1 ? (base1 + AW'(free1)) : (base2 + AW'(free2));
  assign ins_key = ins1 ? key1 : key2;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    key_we = 1'b0;
    row_we = 1'b0;
    key_waddr = clr;
    key_wdata = '0;
    case (state)
      S_CLEAR: begin
        key_we = 1'b1;
      end
      S_POST: begin
        if (op == OP_INSERT && !dup && (ins1 || ins2)) begin
          key_we = 1'b1;
          row_we = 1'b1;
          key_waddr = ins_addr;
          key_wdata = ins_key;
        end
      end
      S_REMOVE: begin
        key_we = mask[idx];
        key_waddr = scan_addr;
      end
      default: begin
        key_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    key_rdata <= key_mem[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[key_waddr] <= row;
    end
    row_rdata <= row_mem[win];
  end

  always_comb begin
    res_found = (op == OP_LOOKUP) && hit;
    res_row = res_found ? row_rdata : '0;
    res_status = STATUS_OK;
    res_removed = '0;
    case (op)
      OP_INSERT: begin
        if (dup) begin
          res_status = STATUS_DUPLICATE;
        end else if (!ins1 && !ins2) begin
          res_status = STATUS_FULL;
        end
      end
      OP_REMOVE: begin
        if (rm_count != NW'(1)) begin
          res_status = STATUS_REMOVE_COUNT;
        end
        res_removed = (32'(rm_count) > 32'd15) ? 4'd15 : REMOVED_W'(rm_count);
      end
      default: begin
        res_status = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      if ((state == S_SCAN || state == S_DRAIN) && pvalid) begin
        if (!pidx[0]) begin
          m1_cur <= slot_hit;
          if (slot_hit) begin
            hit <= 1'b1;
            win <= paddr;
          end
        end else if (slot_hit && !m1_cur) begin
          hit <= 1'b1;
          win <= paddr;
        end
        if (slot_hit) begin
          dup <= 1'b1;
          mask[pidx] <= 1'b1;
          rm_count <= rm_count + NW'(1);
        end
        if (slot_empty) begin
          if (pidx[0]) begin
            empty2 <= empty2 + CW'(1);
            free2 <= ppos;
          end else begin
            empty1 <= empty1 + CW'(1);
            free1 <= ppos;
          end
        end
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(TABLE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op <= s_tuser;
            key1 <= s_tdata[KEY_W-1:0];
            key2 <= s_tdata[2*KEY_W-1:KEY_W];
            row <= s_tdata[IN_DATA_W-1:2*KEY_W];
            rem1 <= '0;
            rem2 <= '0;
            digit <= '0;
            idx <= '0;
            pvalid <= 1'b0;
            m1_cur <= 1'b0;
            hit <= 1'b0;
            win <= '0;
            dup <= 1'b0;
            empty1 <= '0;
            empty2 <= '0;
            free1 <= '0;
            free2 <= '0;
            mask <= '0;
            rm_count <= '0;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          rem1 <= rem1_next;
          rem2 <= rem2_next;
          digit <= digit + DW'(1);
          if (digit == DW'(DIGIT_STEPS - 1)) begin
            base1 <= AW'(int'(rem1_next) * SLOTS_PER_BUCKET);
            base2 <= AW'(int'(rem2_next) * SLOTS_PER_BUCKET);
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          pvalid <= 1'b1;
          pidx <= idx;
          paddr <= scan_addr;
          if (idx == IW'(SCAN_N - 1)) begin
            idx <= '0;
            state <= S_DRAIN;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_DRAIN: begin
          pvalid <= 1'b0;
          state <= S_POST;
        end
        S_POST: begin
          if (op == OP_REMOVE) begin
            state <= S_REMOVE;
          end else begin
            state <= S_DONE;
          end
        end
        S_REMOVE: begin
          if (idx == IW'(SCAN_N - 1)) begin
            idx <= '0;
            state <= S_DONE;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {1'b0, res_removed, res_status, res_row, res_found};
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/tcbht_checker.sv
`timescale 1ns / 1ps

module tcbht_checker
  import tcbht_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // One request at a time: an accepted request drops ready.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in progress");

  // A hit comes only from a lookup, which reports ok and clears nothing.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[OUT_DATA_W-1:17] == '0)
    else $error("found with nonzero status or removed count");

  // A miss carries a zero row.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[16:1] == '0)
    else $error("row reported without a hit");

  // Removing more than one slot always flags the count.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[22:19] != 4'd0 && m_tdata[22:19] != 4'd1
      |-> m_tdata[18:17] == STATUS_REMOVE_COUNT)
    else $error("multiple removal not flagged");

endmodule

bind two_choice_bucket_hash_table tcbht_checker u_tcbht_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tcbht_pkg::*;

  localparam int BUCKET_COUNT = 64;
  localparam int SLOTS_PER_BUCKET = 4;
  localparam int TABLE_DEPTH = BUCKET_COUNT * SLOTS_PER_BUCKET;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int POOL_SIZE = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTED = 50;

  typedef struct packed {
    logic                 found;
    logic [ROW_W-1:0]     found_row;
    logic [1:0]           status;
    logic [REMOVED_W-1:0] removed_count;
  } table_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_tdata;

  logic [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
  logic [ROW_W-1:0] shadow_rows [TABLE_DEPTH];
  table_result_t    pending_results [$];
  table_result_t    oldest_result;

  logic [KEY_W-1:0] pool_low [POOL_SIZE];
  logic [KEY_W-1:0] pool_high [POOL_SIZE];

  int gap_max = 5;
  int stall_max = 5;
  int stall_left = 0;
  int quiet_cycles = 0;
  int error_count = 0;
  int requests_sent = 0;
  int lookup_hits = 0;
  int duplicates_seen = 0;
  int full_rejects = 0;
  int odd_removes = 0;

  two_choice_bucket_hash_table #(
    .BUCKET_COUNT(BUCKET_COUNT),
    .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (error_count < MAX_PRINTED) begin
      $display("MISMATCH at %0t: %s, expected %0h, got %0h", $time, what, want, got);
    end
    error_count++;
  endtask

  function automatic table_result_t predict_table_op(input logic [1:0] op,
      input logic [KEY_W-1:0] key_one, input logic [KEY_W-1:0] key_two,
      input logic [ROW_W-1:0] row);
    table_result_t res;
    int base_one, base_two, empty_one, empty_two, free_one, free_two, hits;
    logic dup, hit_one, hit_two;
    res = '0;
    base_one = int'(key_one % KEY_W'(BUCKET_COUNT)) * SLOTS_PER_BUCKET;
    base_two = int'(key_two % KEY_W'(BUCKET_COUNT)) * SLOTS_PER_BUCKET;
    empty_one = 0;
    empty_two = 0;
    free_one = 0;
    free_two = 0;
    hits = 0;
    dup = 1'b0;
    case (op)
      OP_LOOKUP: begin
        for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
          hit_one = key_one != 0 && shadow_keys[base_one + i] == key_one;
          hit_two = key_two != 0 && shadow_keys[base_two + i] == key_two;
          if (hit_one) begin
            res.found = 1'b1;
            res.found_row = shadow_rows[base_one + i];
          end else if (hit_two) begin
            res.found = 1'b1;
            res.found_row = shadow_rows[base_two + i];
          end
        end
      end
      OP_INSERT: begin
        for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
          if ((key_one != 0 && shadow_keys[base_one + i] == key_one) ||
              (key_two != 0 && shadow_keys[base_two + i] == key_two)) begin
            dup = 1'b1;
          end
          if (shadow_keys[base_one + i] == 0) begin
            free_one = i;
            empty_one++;
          end
          if (shadow_keys[base_two + i] == 0) begin
            free_two = i;
            empty_two++;
          end
        end
        if (dup) begin
          res.status = STATUS_DUPLICATE;
        end else if (empty_one > empty_two) begin
          shadow_keys[base_one + free_one] = key_one;
          shadow_rows[base_one + free_one] = row;
        end else if (empty_two > 0) begin
          shadow_keys[base_two + free_two] = key_two;
          shadow_rows[base_two + free_two] = row;
        end else begin
          res.status = STATUS_FULL;
        end
      end
      OP_REMOVE: begin
        // Both matches of a position are taken before either slot is cleared.
        for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
          hit_one = key_one != 0 && shadow_keys[base_one + i] == key_one;
          hit_two = key_two != 0 && shadow_keys[base_two + i] == key_two;
          if (hit_one) begin
            shadow_keys[base_one + i] = '0;
            hits++;
          end
          if (hit_two) begin
            shadow_keys[base_two + i] = '0;
            hits++;
          end
        end
        if (hits != 1) begin
          res.status = STATUS_REMOVE_COUNT;
        end
        res.removed_count = (hits > 15) ? REMOVED_W'(15) : REMOVED_W'(hits);
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] make_key(input int bucket,
                                                input logic [KEY_W-1:0] upper);
    return upper * KEY_W'(BUCKET_COUNT) + KEY_W'(bucket);
  endfunction

  // Most halves land in a few buckets so that buckets fill up and collide.
  function automatic logic [KEY_W-1:0] random_half();
    int bucket;
    if ($urandom_range(0, 29) == 0) begin
      return '0;
    end
    bucket = ($urandom_range(0, 9) == 0) ? BUCKET_COUNT - 1 : $urandom_range(0, 7);
    return make_key(bucket, {$urandom, $urandom});
  endfunction

  task automatic new_identifier(input int idx);
    pool_low[idx] = random_half();
    pool_high[idx] = ($urandom_range(0, 15) == 0) ? pool_low[idx] : random_half();
  endtask

  task automatic send_request(input logic [1:0] op, input logic [KEY_W-1:0] key_one,
                              input logic [KEY_W-1:0] key_two,
                              input logic [ROW_W-1:0] row);
    int gap;
    table_result_t res;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {row, key_two, key_one};
    s_tuser <= op;
    do @(posedge clk); while (s_tready !== 1'b1);
    res = predict_table_op(op, key_one, key_two, row);
    pending_results.push_back(res);
    requests_sent++;
    if (op == OP_LOOKUP && res.found) lookup_hits++;
    if (res.status == STATUS_DUPLICATE) duplicates_seen++;
    if (res.status == STATUS_FULL) full_rejects++;
    if (res.status == STATUS_REMOVE_COUNT) odd_removes++;
  endtask

  task automatic wait_for_idle_table();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_directed_cases();
    logic [KEY_W-1:0] a_low, a_high;
    a_low = make_key(1, 64'h0123_4567_89ab_cdef);
    a_high = make_key(2, 64'h0fed_cba9_8765_4321);
    send_request(OP_LOOKUP, a_low, a_high, 16'hffff);
    send_request(OP_INSERT, a_low, a_high, 16'hffff);
    send_request(OP_LOOKUP, a_low, a_high, 16'h0000);
    send_request(OP_INSERT, a_low, a_high, 16'h1234);
    send_request(OP_LOOKUP, make_key(1, 64'h77), a_high, 16'h0000);
    // Equal halves in one bucket share a slot, so remove counts it twice.
    send_request(OP_INSERT, '1, '1, 16'h0000);
    send_request(OP_LOOKUP, '1, '1, 16'h0000);
    send_request(OP_REMOVE, '1, '1, 16'h0000);
    for (int i = 0; i < 5; i++) begin
      send_request(OP_INSERT, make_key(9, 64'h100 + i), make_key(9, 64'h200 + i),
                   16'(16'h8000 + i));
    end
    send_request(OP_INSERT, make_key(10, 64'h300), make_key(9, 64'h301), 16'h5555);
    send_request(OP_LOOKUP, make_key(10, 64'h300), '0, 16'h0000);
    send_request(OP_REMOVE, make_key(9, 64'h999), make_key(9, 64'h202), 16'h0000);
    send_request(OP_REMOVE, make_key(9, 64'h999), make_key(9, 64'h202), 16'h0000);
    // A zero half lands as an empty slot and can never be found or removed.
    send_request(OP_INSERT, make_key(11, 64'h400), '0, 16'haaaa);
    send_request(OP_LOOKUP, '0, '0, 16'h0000);
    send_request(OP_REMOVE, '0, '0, 16'h0000);
    send_request(OP_UNUSED, '1, '1, '1);
    send_request(OP_REMOVE, a_low, a_high, 16'hffff);
    wait_for_idle_table();
  endtask

  task automatic test_random_traffic(input int count, input int sender_gap,
                                     input int receiver_stall);
    int pick, idx;
    logic [1:0] op;
    logic [KEY_W-1:0] key_one, key_two;
    gap_max = sender_gap;
    stall_max = receiver_stall;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      idx = $urandom_range(0, POOL_SIZE - 1);
      key_one = pool_low[idx];
      key_two = pool_high[idx];
      if (pick < 35) begin
        op = OP_INSERT;
      end else if (pick < 70) begin
        op = OP_LOOKUP;
      end else if (pick < 93) begin
        op = OP_REMOVE;
      end else begin
        op = (pick < 97) ? 2'($urandom_range(0, 2)) : OP_UNUSED;
        key_one = {$urandom, $urandom};
        key_two = {$urandom, $urandom};
      end
      if ($urandom_range(0, 19) == 0) begin
        new_identifier(idx);
      end
      send_request(op, key_one, key_two, 16'($urandom));
    end
    wait_for_idle_table();
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid === 1'b1 && m_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request waiting", 32'd0, 32'(m_tdata));
        end else begin
          oldest_result = pending_results.pop_front();
          if (m_tdata[0] !== oldest_result.found)
            report_mismatch("found", 32'(oldest_result.found), 32'(m_tdata[0]));
          if (m_tdata[16:1] !== oldest_result.found_row)
            report_mismatch("found_row", 32'(oldest_result.found_row),
                            32'(m_tdata[16:1]));
          if (m_tdata[18:17] !== oldest_result.status)
            report_mismatch("status", 32'(oldest_result.status), 32'(m_tdata[18:17]));
          if (m_tdata[22:19] !== oldest_result.removed_count)
            report_mismatch("removed_count", 32'(oldest_result.removed_count),
                            32'(m_tdata[22:19]));
          if (m_tdata[23] !== 1'b0)
            report_mismatch("reserved bit", 32'd0, 32'(m_tdata[23]));
        end
        stall_left = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
        m_tready <= (stall_left == 0);
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= (stall_left == 0);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      shadow_keys[i] = '0;
      shadow_rows[i] = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      new_identifier(i);
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_random_traffic(450, 5, 5);
    test_random_traffic(450, 0, 0);
    test_random_traffic(450, 0, 5);
    test_random_traffic(450, 5, 0);

    repeat (50) @(posedge clk);
    $display("Covered %0d requests: %0d lookup hits, %0d duplicate inserts,",
             requests_sent, lookup_hits, duplicates_seen);
    $display("%0d full-bucket rejects and %0d removes that cleared other than one slot.",
             full_rejects, odd_removes);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/tcbht_pkg.sv
hdl/two_choice_bucket_hash_table.sv
hdl/tcbht_checker.sv
verif/testbench.sv
